[src/frvr_pkg.sv]
// Shared types and constants for the mesh compaction / vertex renumbering block.
package frvr_pkg;

    // Field widths
    localparam int VTX_W     = 12;            // vertex number and new label
    localparam int VTX_DEPTH = 4096;          // entries in the label memory
    localparam int CNT_V_W   = 13;            // vertex counter, holds VTX_DEPTH
    localparam int IDX_W     = 16;            // facet / edge index
    localparam int IDX_CNT_W = IDX_W + 1;     // index counter, MSB marks saturation
    localparam int REG_W     = 6;             // region number
    localparam int NUM_REGIONS = 64;          // bits in the removal mask
    localparam int OP_W      = 2;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_TRI   = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_NEW   = 2'd3;

    // Command kinds after classification
    localparam int K_W = 3;
    localparam logic [K_W-1:0] K_DROP  = 3'd0;
    localparam logic [K_W-1:0] K_TRI   = 3'd1;
    localparam logic [K_W-1:0] K_EDGE  = 3'd2;
    localparam logic [K_W-1:0] K_QUERY = 3'd3;
    localparam logic [K_W-1:0] K_CLEAR = 3'd4;

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef struct packed {
        logic [K_W-1:0]   kind;
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic [VTX_W-1:0] vc;
        logic [REG_W-1:0] region;
    } t_cmd;

    // One label memory entry
    typedef struct packed {
        logic             valid;
        logic [VTX_W-1:0] label;
    } t_ent;

    typedef struct packed {
        logic             kept;
        logic [VTX_W-1:0] new_a;
        logic [VTX_W-1:0] new_b;
        logic [VTX_W-1:0] new_c;
        logic [REG_W-1:0] region_out;
        logic [IDX_W-1:0] new_index;
        logic             count_full;
    } t_res;

endpackage

[src/frvr_front.sv]
// Front end: removal mask register and classification of incoming items.
module frvr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_mask_we,
    input  logic [frvr_pkg::NUM_REGIONS-1:0] i_mask_wdata,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [frvr_pkg::OP_W-1:0]     i_op,
    input  logic [frvr_pkg::VTX_W-1:0]    i_vertex_a,
    input  logic [frvr_pkg::VTX_W-1:0]    i_vertex_b,
    input  logic [frvr_pkg::VTX_W-1:0]    i_vertex_c,
    input  logic [frvr_pkg::REG_W-1:0]    i_region_id,
    input  logic                          i_in_selected_subset,
    output logic                          o_cmd_push,
    output frvr_pkg::t_cmd                o_cmd
);
    import frvr_pkg::*;

    logic [NUM_REGIONS-1:0] r_mask;
    logic                   tri_removed;

    // Removal mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_mask_we) begin
            r_mask <= i_mask_wdata;
        end
    end

    // Classify the transaction
    assign tri_removed = i_in_selected_subset | r_mask[i_region_id];
    assign o_cmd_push  = i_push & ~i_full;

    always_comb begin
        o_cmd.va     = i_vertex_a;
        o_cmd.vb     = i_vertex_b;
        o_cmd.vc     = i_vertex_c;
        o_cmd.region = i_region_id;
        case (i_op)
            OP_TRI:   o_cmd.kind = tri_removed ? K_DROP : K_TRI;
            OP_EDGE:  o_cmd.kind = K_EDGE;
            OP_QUERY: o_cmd.kind = K_QUERY;
            OP_NEW:   o_cmd.kind = K_CLEAR;
            default:  o_cmd.kind = K_DROP;
        endcase
    end

endmodule

[src/frvr_cmd_fifo.sv]
// Short command queue between the front end and the back end.
module frvr_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  frvr_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output frvr_pkg::t_cmd o_data
);
    import frvr_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wp;
    logic [CMD_PTR_W-1:0] r_rp;
    logic [CMD_CNT_W-1:0] r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

[src/frvr_back.sv]
// Back end: label memory, counters and the per-command sequencer.
module frvr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  frvr_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    output frvr_pkg::t_res o_res,
    output logic           o_empty,
    input  logic           i_pop
);
    import frvr_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [1:0] SLOT_C = 2'd2;

    // Label memory
    t_ent             r_mem [VTX_DEPTH];
    t_ent             r_rd_data;
    logic             rd_en;
    logic [VTX_W-1:0] rd_addr;
    logic             mem_we;
    logic [VTX_W-1:0] wr_addr;
    t_ent             wr_data;

    // Sequencer state
    logic [2:0]           r_state,     n_state;
    logic [1:0]           r_slot,      n_slot;
    logic [1:0]           r_last,      n_last;
    logic [K_W-1:0]       r_kind,      n_kind;
    logic [VTX_W-1:0]     r_v   [3];
    logic [VTX_W-1:0]     n_v   [3];
    logic [REG_W-1:0]     r_region,    n_region;
    t_ent                 r_ent [3];
    t_ent                 n_ent [3];
    logic [VTX_W-1:0]     r_lbl [3];
    logic [VTX_W-1:0]     n_lbl [3];
    logic [2:0]           r_fresh,     n_fresh;
    logic [CNT_V_W-1:0]   r_vcnt,      n_vcnt;
    logic [IDX_CNT_W-1:0] r_fcnt,      n_fcnt;
    logic [IDX_CNT_W-1:0] r_ecnt,      n_ecnt;
    logic [VTX_W-1:0]     r_clr_addr,  n_clr_addr;
    logic                 r_clr_reply, n_clr_reply;
    t_res                 r_res,       n_res;
    t_res                 r_out;
    logic                 r_out_valid;

    // Triangle evaluation terms
    logic               same_ba, same_ca, same_cb;
    logic               fa, fb, fc;
    logic [1:0]         need;
    logic [CNT_V_W-1:0] room;
    logic [VTX_W-1:0]   vbase, la, lb, lc;
    logic               tri_refuse;
    logic               emit_ok;
    logic [1:0]         slot_nx;

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign emit_ok   = !r_out_valid || i_pop;
    assign slot_nx   = r_slot + 2'd1;
    assign o_res     = r_out;
    assign o_empty   = !r_out_valid;

    // Memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_cmd.va;
        mem_we  = 1'b0;
        wr_addr = r_v[r_slot];
        wr_data = '{valid: 1'b1, label: r_lbl[r_slot]};
        case (r_state)
            S_IDLE: begin
                rd_en   = o_cmd_pop;
                rd_addr = i_cmd.va;
            end
            S_LOOK: begin
                rd_en   = (r_slot != r_last);
                rd_addr = r_v[slot_nx];
            end
            S_WRITE: begin
                mem_we  = r_fresh[r_slot];
            end
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    // New labels for a triangle, repeated vertices share the label of their first occurrence
    always_comb begin
        same_ba    = (r_v[1] == r_v[0]);
        same_ca    = (r_v[2] == r_v[0]);
        same_cb    = (r_v[2] == r_v[1]);
        fa         = !r_ent[0].valid;
        fb         = !r_ent[1].valid && !same_ba;
        fc         = !r_ent[2].valid && !same_ca && !same_cb;
        need       = {1'b0, fa} + {1'b0, fb} + {1'b0, fc};
        room       = CNT_V_W'(VTX_DEPTH) - r_vcnt;
        vbase      = r_vcnt[VTX_W-1:0];
        la         = fa ? vbase : r_ent[0].label;
        lb         = same_ba ? la : (fb ? vbase + VTX_W'(fa) : r_ent[1].label);
        lc         = same_ca ? la :
                     same_cb ? lb :
                     fc ? vbase + VTX_W'(fa) + VTX_W'(fb) : r_ent[2].label;
        tri_refuse = r_fcnt[IDX_W] || (CNT_V_W'(need) > room);
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_last      = r_last;
        n_kind      = r_kind;
        n_v         = r_v;
        n_region    = r_region;
        n_ent       = r_ent;
        n_lbl       = r_lbl;
        n_fresh     = r_fresh;
        n_vcnt      = r_vcnt;
        n_fcnt      = r_fcnt;
        n_ecnt      = r_ecnt;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_res       = r_res;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == VTX_W'(VTX_DEPTH - 1)) begin
                    n_res   = '0;
                    n_state = r_clr_reply ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd_pop) begin
                    n_kind   = i_cmd.kind;
                    n_v[0]   = i_cmd.va;
                    n_v[1]   = i_cmd.vb;
                    n_v[2]   = i_cmd.vc;
                    n_region = i_cmd.region;
                    n_slot   = '0;
                    n_res    = '0;
                    case (i_cmd.kind)
                        K_TRI: begin
                            n_last  = SLOT_C;
                            n_state = S_LOOK;
                        end
                        K_EDGE: begin
                            n_last  = 2'd1;
                            n_state = S_LOOK;
                        end
                        K_QUERY: begin
                            n_last  = 2'd0;
                            n_state = S_LOOK;
                        end
                        K_CLEAR: begin
                            n_vcnt      = '0;
                            n_fcnt      = '0;
                            n_ecnt      = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_ent[r_slot] = r_rd_data;
                if (r_slot == r_last) n_state = S_EVAL;
                else                  n_slot  = slot_nx;
            end
            S_EVAL: begin
                n_res   = '0;
                n_state = S_EMIT;
                case (r_kind)
                    K_TRI: begin
                        if (tri_refuse) begin
                            n_res.count_full = 1'b1;
                        end else begin
                            n_res.kept       = 1'b1;
                            n_res.new_a      = la;
                            n_res.new_b      = lb;
                            n_res.new_c      = lc;
                            n_res.region_out = r_region;
                            n_res.new_index  = r_fcnt[IDX_W-1:0];
                            n_fcnt           = r_fcnt + 1'b1;
                            n_vcnt           = r_vcnt + CNT_V_W'(need);
                            n_lbl[0]         = la;
                            n_lbl[1]         = lb;
                            n_lbl[2]         = lc;
                            n_fresh          = {fc, fb, fa};
                            n_slot           = '0;
                            n_state          = S_WRITE;
                        end
                    end
                    K_EDGE: begin
                        if (r_ent[0].valid && r_ent[1].valid) begin
                            if (r_ecnt[IDX_W]) begin
                                n_res.count_full = 1'b1;
                            end else begin
                                n_res.kept      = 1'b1;
                                n_res.new_a     = r_ent[0].label;
                                n_res.new_b     = r_ent[1].label;
                                n_res.new_index = r_ecnt[IDX_W-1:0];
                                n_ecnt          = r_ecnt + 1'b1;
                            end
                        end
                    end
                    K_QUERY: begin
                        n_res.kept  = r_ent[0].valid;
                        n_res.new_a = r_ent[0].valid ? r_ent[0].label : '0;
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_WRITE: begin
                if (r_slot == SLOT_C) n_state = S_EMIT;
                else                  n_slot  = slot_nx;
            end
            S_EMIT: begin
                if (emit_ok) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_last      <= '0;
            r_vcnt      <= '0;
            r_fcnt      <= '0;
            r_ecnt      <= '0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_last      <= n_last;
            r_vcnt      <= n_vcnt;
            r_fcnt      <= n_fcnt;
            r_ecnt      <= n_ecnt;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_v      <= n_v;
        r_region <= n_region;
        r_ent    <= n_ent;
        r_lbl    <= n_lbl;
        r_fresh  <= n_fresh;
        r_res    <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) r_out <= r_res;
    end

`ifndef SYNTHESIS
    a_mem_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_WRITE || r_state == S_CLEAR))
        else $error("label memory written outside write or clear phase");

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= CNT_V_W'(VTX_DEPTH))
        else $error("vertex counter beyond label memory depth");

    a_fcnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fcnt != $past(r_fcnt)) |->
            (r_fcnt == $past(r_fcnt) + 1'b1 || r_fcnt == '0))
        else $error("facet counter jumped");

    a_full_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.count_full) |-> !r_out.kept)
        else $error("refused transaction reported as kept");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && !r_out_valid || r_state == S_IDLE))
        else $error("command taken while sequencer busy");
`endif

endmodule

[src/facet_removal_vertex_renumbering.sv]
// Top level: mesh compaction with vertex renumbering.
// Triangles, feature edges, point queries and new-mesh items go in through
// a queue-style port and each gives exactly one result, in order. A front
// end classifies items (removal mask, subset flag) into a two-entry command
// queue; a back end walks each command against a single-ported 4096-entry
// label memory, one vertex per cycle. A triangle reads three vertices, is
// evaluated, if kept steps through three write slots and gives its result;
// edges read two vertices, point queries one, removed triangles none. The
// label memory is cleared after reset and each new-mesh item, while items
// queue; full rises once the command queue holds two. Index counters
// saturate after 65536 indices; later triangles or edges get count_full.
module facet_removal_vertex_renumbering (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_mask_we,
    input  logic [frvr_pkg::NUM_REGIONS-1:0] i_mask_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic [frvr_pkg::OP_W-1:0]       i_op,
    input  logic [frvr_pkg::VTX_W-1:0]      i_vertex_a,
    input  logic [frvr_pkg::VTX_W-1:0]      i_vertex_b,
    input  logic [frvr_pkg::VTX_W-1:0]      i_vertex_c,
    input  logic [frvr_pkg::REG_W-1:0]      i_region_id,
    input  logic                            i_in_selected_subset,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_kept,
    output logic [frvr_pkg::VTX_W-1:0]      o_new_a,
    output logic [frvr_pkg::VTX_W-1:0]      o_new_b,
    output logic [frvr_pkg::VTX_W-1:0]      o_new_c,
    output logic [frvr_pkg::REG_W-1:0]      o_region_out,
    output logic [frvr_pkg::IDX_W-1:0]      o_new_index,
    output logic                            o_count_full
);
    import frvr_pkg::*;

    t_cmd front_cmd;
    logic front_push;
    t_cmd q_cmd;
    logic q_empty;
    logic q_pop;
    t_res res;

    frvr_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_mask_we            (i_mask_we),
        .i_mask_wdata         (i_mask_wdata),
        .i_push               (push),
        .i_full               (full),
        .i_op                 (i_op),
        .i_vertex_a           (i_vertex_a),
        .i_vertex_b           (i_vertex_b),
        .i_vertex_c           (i_vertex_c),
        .i_region_id          (i_region_id),
        .i_in_selected_subset (i_in_selected_subset),
        .o_cmd_push           (front_push),
        .o_cmd                (front_cmd)
    );

    frvr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    frvr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // Result fields
    assign o_kept       = res.kept;
    assign o_new_a      = res.new_a;
    assign o_new_b      = res.new_b;
    assign o_new_c      = res.new_c;
    assign o_region_out = res.region_out;
    assign o_new_index  = res.new_index;
    assign o_count_full = res.count_full;

endmodule
